>>> sv/mmp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mmp_pkg;

   // limb layout, radix 2^51
   localparam int LIMB_COUNT = 5;
   localparam int LIMB_BITS  = 51;
   localparam int Z1_BITS    = LIMB_BITS + 1;

   // multiplier operand: a limb or 19 times a limb
   localparam int OP_BITS   = 56;
   localparam int A_LO_BITS = 28;
   localparam int A_HI_BITS = OP_BITS - A_LO_BITS;
   localparam int B_LO_BITS = 26;
   localparam int B_HI_BITS = LIMB_BITS - B_LO_BITS;
   localparam int PP_BITS   = A_LO_BITS + B_LO_BITS;
   localparam int PROD_BITS = OP_BITS + LIMB_BITS;

   // column sums and the carries between them
   localparam int COL_BITS   = PROD_BITS + 3;
   localparam int CARRY_BITS = COL_BITS - LIMB_BITS;
   localparam int FOLD_BITS  = 64;
   localparam int FOLD_HI_BITS = FOLD_BITS - LIMB_BITS;
   localparam int CARRY2_BITS  = FOLD_HI_BITS + 1;

   // pipeline stage positions
   localparam int STG_IN    = 0;
   localparam int STG_PP    = 1;
   localparam int STG_TERM  = 2;
   localparam int STG_COL   = 3;
   localparam int STG_STEP0 = 4;
   localparam int STG_FOLD  = STG_STEP0 + LIMB_COUNT;
   localparam int STG_OUT   = STG_FOLD + 1;
   localparam int PIPE_DEPTH = STG_OUT + 1;

   typedef logic [LIMB_BITS-1:0]  limb_type;
   typedef logic [OP_BITS-1:0]    op_type;
   typedef logic [COL_BITS-1:0]   col_type;
   typedef logic [CARRY_BITS-1:0] carry_type;

   typedef struct packed {
      limb_type x_limb0;
      limb_type x_limb1;
      limb_type x_limb2;
      limb_type x_limb3;
      limb_type x_limb4;
      limb_type y_limb0;
      limb_type y_limb1;
      limb_type y_limb2;
      limb_type y_limb3;
      limb_type y_limb4;
   } mmp_req_type;

   typedef struct packed {
      limb_type               z_limb0;
      logic [Z1_BITS-1:0]     z_limb1;
      limb_type               z_limb2;
      limb_type               z_limb3;
      limb_type               z_limb4;
   } mmp_rsp_type;

   typedef struct packed {
      logic pp_load;
      logic term_load;
      logic col_load;
   } mmp_lane_ctl_type;

   typedef struct packed {
      logic [LIMB_COUNT-1:0] step_load;
      logic                  fold_load;
      logic                  out_load;
   } mmp_merge_ctl_type;

endpackage

`default_nettype wire

>>> sv/mmp_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module mmp_lane
   import mmp_pkg::*;
(
   input  logic                                  clock,
   input  mmp_lane_ctl_type                      ctl,
   input  logic [LIMB_COUNT-1:0][OP_BITS-1:0]    a,
   input  logic [LIMB_COUNT-1:0][LIMB_BITS-1:0]  b,
   output col_type                               col_sum
);

   logic [PP_BITS-1:0]   pp_ll_ff [LIMB_COUNT];
   logic [PP_BITS-1:0]   pp_lh_ff [LIMB_COUNT];
   logic [PP_BITS-1:0]   pp_hl_ff [LIMB_COUNT];
   logic [PP_BITS-1:0]   pp_hh_ff [LIMB_COUNT];
   logic [PP_BITS-1:0]   pp_ll_in [LIMB_COUNT];
   logic [PP_BITS-1:0]   pp_lh_in [LIMB_COUNT];
   logic [PP_BITS-1:0]   pp_hl_in [LIMB_COUNT];
   logic [PP_BITS-1:0]   pp_hh_in [LIMB_COUNT];
   logic [PROD_BITS-1:0] term_ff  [LIMB_COUNT];
   logic [PROD_BITS-1:0] term_in  [LIMB_COUNT];
   col_type              col_ff;
   col_type              col_in;

   // four narrow partial products per term
   always_comb begin
      for (int t = 0; t < LIMB_COUNT; t++) begin
         pp_ll_in[t] = PP_BITS'(a[t][A_LO_BITS-1:0]) * PP_BITS'(b[t][B_LO_BITS-1:0]);
         pp_lh_in[t] = PP_BITS'(a[t][A_LO_BITS-1:0]) * PP_BITS'(b[t][LIMB_BITS-1:B_LO_BITS]);
         pp_hl_in[t] = PP_BITS'(a[t][OP_BITS-1:A_LO_BITS]) * PP_BITS'(b[t][B_LO_BITS-1:0]);
         pp_hh_in[t] = PP_BITS'(a[t][OP_BITS-1:A_LO_BITS])
                     * PP_BITS'(b[t][LIMB_BITS-1:B_LO_BITS]);
      end
   end

   // recombine the partials into each full term
   always_comb begin
      for (int t = 0; t < LIMB_COUNT; t++) begin
         term_in[t] = PROD_BITS'(pp_ll_ff[t])
                    + (PROD_BITS'(pp_lh_ff[t]) << B_LO_BITS)
                    + (PROD_BITS'(pp_hl_ff[t]) << A_LO_BITS)
                    + (PROD_BITS'(pp_hh_ff[t]) << (A_LO_BITS + B_LO_BITS));
      end
   end

   // column sum of the five terms
   always_comb begin
      col_in = '0;
      for (int t = 0; t < LIMB_COUNT; t++) begin
         col_in = col_in + COL_BITS'(term_ff[t]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.pp_load) begin
         for (int t = 0; t < LIMB_COUNT; t++) begin
            pp_ll_ff[t] <= pp_ll_in[t];
            pp_lh_ff[t] <= pp_lh_in[t];
            pp_hl_ff[t] <= pp_hl_in[t];
            pp_hh_ff[t] <= pp_hh_in[t];
         end
      end
      if (ctl.term_load) begin
         for (int t = 0; t < LIMB_COUNT; t++) begin
            term_ff[t] <= term_in[t];
         end
      end
      if (ctl.col_load) begin
         col_ff <= col_in;
      end
   end

   assign col_sum = col_ff;

endmodule

`default_nettype wire

>>> sv/mmp_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module mmp_merge
   import mmp_pkg::*;
(
   input  logic                                 clock,
   input  mmp_merge_ctl_type                    ctl,
   input  logic [LIMB_COUNT-1:0][COL_BITS-1:0]  col,
   output mmp_rsp_type                          rsp_data
);

   logic [LIMB_COUNT-1:0][COL_BITS-1:0]  col_ff   [LIMB_COUNT];
   logic [LIMB_COUNT-1:0][LIMB_BITS-1:0] v_ff     [LIMB_COUNT];
   logic [LIMB_COUNT-1:0][LIMB_BITS-1:0] v_in     [LIMB_COUNT];
   carry_type                            carry_ff [LIMB_COUNT];
   col_type                              acc_in   [LIMB_COUNT];
   logic [FOLD_BITS-1:0]                 fold_ff;
   logic [FOLD_BITS-1:0]                 fold_in;
   logic [LIMB_COUNT-1:0][LIMB_BITS-1:0] fold_v_ff;
   logic [Z1_BITS-1:0]                   low_sum;
   logic [CARRY2_BITS-1:0]               carry2;
   mmp_rsp_type                          rsp_ff;
   mmp_rsp_type                          rsp_in;

   // carry chain, one column per stage
   always_comb begin
      acc_in[0] = col[0];
      v_in[0]   = '0;
      v_in[0][0] = acc_in[0][LIMB_BITS-1:0];
      for (int k = 1; k < LIMB_COUNT; k++) begin
         acc_in[k]  = col_ff[k-1][k] + COL_BITS'(carry_ff[k-1]);
         v_in[k]    = v_ff[k-1];
         v_in[k][k] = acc_in[k][LIMB_BITS-1:0];
      end
   end

   // top carry times 19, as 16 + 2 + 1, kept modulo 2^64
   always_comb begin
      fold_in = (FOLD_BITS'(carry_ff[LIMB_COUNT-1]) << 4)
              + (FOLD_BITS'(carry_ff[LIMB_COUNT-1]) << 1)
              + FOLD_BITS'(carry_ff[LIMB_COUNT-1]);
   end

   // fold into limb 0, spill into limb 1
   always_comb begin
      low_sum = Z1_BITS'(fold_v_ff[0]) + Z1_BITS'(fold_ff[LIMB_BITS-1:0]);
      carry2  = CARRY2_BITS'(low_sum[LIMB_BITS])
              + CARRY2_BITS'(fold_ff[FOLD_BITS-1:LIMB_BITS]);
      rsp_in.z_limb0 = low_sum[LIMB_BITS-1:0];
      rsp_in.z_limb1 = Z1_BITS'(fold_v_ff[1]) + Z1_BITS'(carry2);
      rsp_in.z_limb2 = fold_v_ff[2];
      rsp_in.z_limb3 = fold_v_ff[3];
      rsp_in.z_limb4 = fold_v_ff[4];
   end

   always_ff @(posedge clock) begin
      if (ctl.step_load[0]) begin
         col_ff[0]   <= col;
         v_ff[0]     <= v_in[0];
         carry_ff[0] <= acc_in[0][COL_BITS-1:LIMB_BITS];
      end
      for (int k = 1; k < LIMB_COUNT; k++) begin
         if (ctl.step_load[k]) begin
            col_ff[k]   <= col_ff[k-1];
            v_ff[k]     <= v_in[k];
            carry_ff[k] <= acc_in[k][COL_BITS-1:LIMB_BITS];
         end
      end
      if (ctl.fold_load) begin
         fold_ff   <= fold_in;
         fold_v_ff <= v_ff[LIMB_COUNT-1];
      end
      if (ctl.out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

>>> sv/modular_multiply_p25519.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  handshake               payload
// req      in   req_valid / req_stall   mmp_req_type, operands x and y, 5 x 51-bit limbs
// rsp      out  rsp_valid / rsp_stall   mmp_rsp_type, product z, limb 1 is 52 bits
//
// one item per cycle, unless a stall on rsp backs up the pipeline
// the pipeline holds an input stage, three lane stages (partials, terms, column), the
// five-step carry chain in the merge and two fold stages
// reset clears the stage valid bits only; datapath registers are not reset
// a stall on rsp holds only the stages that are full, so empty slots are squeezed out
// and req_stall rises only when every stage holds an item

module modular_multiply_p25519
   import mmp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  mmp_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output mmp_rsp_type rsp_data
);

   logic [PIPE_DEPTH-1:0]                vld_ff;
   logic [PIPE_DEPTH-1:0]                vld_src;
   logic [PIPE_DEPTH:0]                  ready;
   logic [PIPE_DEPTH-1:0]                load;
   logic [LIMB_COUNT-1:0][LIMB_BITS-1:0] x_ff;
   logic [LIMB_COUNT-1:0][LIMB_BITS-1:0] y_ff;
   logic [LIMB_COUNT-1:0][OP_BITS-1:0]   x19_ff;
   logic [LIMB_COUNT-1:0][LIMB_BITS-1:0] x_in;
   logic [LIMB_COUNT-1:0][LIMB_BITS-1:0] y_in;
   logic [LIMB_COUNT-1:0][OP_BITS-1:0]   x19_in;
   logic [LIMB_COUNT-1:0][COL_BITS-1:0]  col;
   mmp_lane_ctl_type                     lane_ctl;
   mmp_merge_ctl_type                    merge_ctl;

   // stage advance: a stage moves when it is empty or the next one moves
   always_comb begin
      ready[PIPE_DEPTH] = !rsp_stall;
      for (int k = PIPE_DEPTH - 1; k >= 0; k--) begin
         ready[k] = !vld_ff[k] || ready[k+1];
      end
      vld_src[STG_IN] = req_valid;
      for (int k = 1; k < PIPE_DEPTH; k++) begin
         vld_src[k] = vld_ff[k-1];
      end
      load = ready[PIPE_DEPTH-1:0] & vld_src;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < PIPE_DEPTH; k++) begin
            if (ready[k]) begin
               vld_ff[k] <= vld_src[k];
            end
         end
      end
   end

   // input stage, with 19 times each x limb for the folded terms
   always_comb begin
      x_in = {req_data.x_limb4, req_data.x_limb3, req_data.x_limb2,
              req_data.x_limb1, req_data.x_limb0};
      y_in = {req_data.y_limb4, req_data.y_limb3, req_data.y_limb2,
              req_data.y_limb1, req_data.y_limb0};
      for (int j = 0; j < LIMB_COUNT; j++) begin
         x19_in[j] = (OP_BITS'(x_in[j]) << 4) + (OP_BITS'(x_in[j]) << 1)
                   + OP_BITS'(x_in[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (load[STG_IN]) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         x19_ff <= x19_in;
      end
   end

   assign lane_ctl.pp_load   = load[STG_PP];
   assign lane_ctl.term_load = load[STG_TERM];
   assign lane_ctl.col_load  = load[STG_COL];

   // one lane per output column
   for (genvar i = 0; i < LIMB_COUNT; i++) begin : g_lane
      logic [LIMB_COUNT-1:0][OP_BITS-1:0]   lane_a;
      logic [LIMB_COUNT-1:0][LIMB_BITS-1:0] lane_b;

      for (genvar j = 0; j < LIMB_COUNT; j++) begin : g_term
         if (j <= i) begin : g_plain
            assign lane_a[j] = OP_BITS'(x_ff[j]);
            assign lane_b[j] = y_ff[i-j];
         end else begin : g_folded
            assign lane_a[j] = x19_ff[j];
            assign lane_b[j] = y_ff[LIMB_COUNT-j+i];
         end
      end

      mmp_lane u_lane (
         .clock   (clock),
         .ctl     (lane_ctl),
         .a       (lane_a),
         .b       (lane_b),
         .col_sum (col[i])
      );
   end

   assign merge_ctl.step_load = load[STG_FOLD-1:STG_STEP0];
   assign merge_ctl.fold_load = load[STG_FOLD];
   assign merge_ctl.out_load  = load[STG_OUT];

   mmp_merge u_merge (
      .clock    (clock),
      .ctl      (merge_ctl),
      .col      (col),
      .rsp_data (rsp_data)
   );

   assign req_stall = !ready[STG_IN];
   assign rsp_valid = vld_ff[STG_OUT];

endmodule

`default_nettype wire

>>> sv/mmp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mmp_checker
   import mmp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input mmp_rsp_type rsp_data
);

   // after reset the pipeline is empty and open
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   // a waiting result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // the input side only stalls when every stage is full and the output is blocked
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with room in the pipeline");

   // with no output stall an accepted item moves through every stage and reaches the output
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
      ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
      ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("item did not reach the output in time");

endmodule

bind modular_multiply_p25519 mmp_checker u_mmp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

>>> tb/mmp_product_checker.sv
`timescale 1ns / 1ps

module mmp_product_checker
   import mmp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  mmp_req_type req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  mmp_rsp_type rsp_data,
   output int          fail_count,
   output int          outstanding
);

   localparam logic [127:0] FOLD_FACTOR = 128'd19;
   localparam int REPORT_LIMIT = 10;

   mmp_rsp_type product_q [$];
   int          result_index = 0;
   int          mismatches = 0;

   // schoolbook product mod 2^255-19, partly reduced, limb 1 may hold 52 bits
   function automatic mmp_rsp_type mul_mod_p25519(input mmp_req_type a);
      limb_type     xs [LIMB_COUNT];
      limb_type     ys [LIMB_COUNT];
      limb_type     col [LIMB_COUNT];
      logic [127:0] acc;
      logic [63:0]  fold;
      logic [63:0]  low_sum;
      logic [63:0]  carry;
      logic [63:0]  mid;
      mmp_rsp_type  r;
      xs = '{a.x_limb0, a.x_limb1, a.x_limb2, a.x_limb3, a.x_limb4};
      ys = '{a.y_limb0, a.y_limb1, a.y_limb2, a.y_limb3, a.y_limb4};
      acc = '0;
      // column sums with the upper partial products folded by 19
      for (int i = 0; i < LIMB_COUNT; i++) begin
         for (int j = 0; j < LIMB_COUNT; j++) begin
            if (j <= i) begin
               acc = acc + 128'(xs[j]) * 128'(ys[i - j]);
            end else begin
               acc = acc + 128'(xs[j]) * FOLD_FACTOR * 128'(ys[LIMB_COUNT - j + i]);
            end
         end
         col[i] = acc[LIMB_BITS-1:0];
         acc = acc >> LIMB_BITS;
      end
      // top carry folded back into limbs 0 and 1
      fold    = acc[63:0] * 64'd19;
      low_sum = 64'(col[0]) + 64'(fold[LIMB_BITS-1:0]);
      carry   = (low_sum >> LIMB_BITS) + (fold >> LIMB_BITS);
      mid     = 64'(col[1]) + carry;
      r.z_limb0 = low_sum[LIMB_BITS-1:0];
      r.z_limb1 = mid[Z1_BITS-1:0];
      r.z_limb2 = col[2];
      r.z_limb3 = col[3];
      r.z_limb4 = col[4];
      return r;
   endfunction

   task automatic check_limb(input string name, input logic [63:0] want,
                             input logic [63:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("mismatch on result %0d, %s: expected %h, got %h",
                     result_index, name, want, got);
         end
      end
   endtask

   // record accepted operands, compare accepted products
   always @(posedge clock) begin
      mmp_rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            product_q.push_back(mul_mod_p25519(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (product_q.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("unexpected result %0d: %h", result_index, rsp_data);
               end
            end else begin
               want = product_q.pop_front();
               check_limb("z_limb0", 64'(want.z_limb0), 64'(rsp_data.z_limb0));
               check_limb("z_limb1", 64'(want.z_limb1), 64'(rsp_data.z_limb1));
               check_limb("z_limb2", 64'(want.z_limb2), 64'(rsp_data.z_limb2));
               check_limb("z_limb3", 64'(want.z_limb3), 64'(rsp_data.z_limb3));
               check_limb("z_limb4", 64'(want.z_limb4), 64'(rsp_data.z_limb4));
            end
            result_index++;
         end
      end
      outstanding <= product_q.size();
      fail_count  <= mismatches;
   end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import mmp_pkg::*;

   localparam int RESET_CYCLES  = 7;
   localparam int ITEMS_PER_PHASE = 338;
   localparam int HOLD_CYCLES   = 200;
   localparam int DRAIN_CYCLES  = 20;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam limb_type LIMB_MAX = {LIMB_BITS{1'b1}};
   localparam limb_type P_LOW    = LIMB_MAX - limb_type'(18);

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   mmp_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   mmp_rsp_type rsp_data;

   int fail_count;
   int outstanding;
   int send_idle_pct = 0;
   int stall_pct = 0;
   bit hold_request = 1'b0;
   int hold_left = 0;
   int quiet_cycles = 0;

   modular_multiply_p25519 dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   mmp_product_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   // limb values biased towards the edges
   function automatic limb_type rand_limb();
      case ($urandom_range(7))
         0: return '0;
         1: return LIMB_MAX;
         2: return limb_type'($urandom_range(255));
         3: return LIMB_MAX - limb_type'($urandom_range(255));
         default: return limb_type'({$urandom, $urandom});
      endcase
   endfunction

   function automatic mmp_req_type rand_operands();
      mmp_req_type d;
      d.x_limb0 = rand_limb();
      d.x_limb1 = rand_limb();
      d.x_limb2 = rand_limb();
      d.x_limb3 = rand_limb();
      d.x_limb4 = rand_limb();
      d.y_limb0 = rand_limb();
      d.y_limb1 = rand_limb();
      d.y_limb2 = rand_limb();
      d.y_limb3 = rand_limb();
      d.y_limb4 = rand_limb();
      return d;
   endfunction

   // offer one item and hold it until taken; stall is sampled mid-cycle
   task automatic send_item(input mmp_req_type d);
      bit taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (outstanding == 0);
      @(posedge clock);
   endtask

   // one operand limb at its maximum in each operand, the rest zero
   function automatic mmp_req_type single_limbs(input int xk, input int yk);
      mmp_req_type d;
      limb_type    xs [LIMB_COUNT];
      limb_type    ys [LIMB_COUNT];
      for (int i = 0; i < LIMB_COUNT; i++) begin
         xs[i] = (i == xk) ? LIMB_MAX : '0;
         ys[i] = (i == yk) ? LIMB_MAX : '0;
      end
      d = '{xs[0], xs[1], xs[2], xs[3], xs[4], ys[0], ys[1], ys[2], ys[3], ys[4]};
      return d;
   endfunction

   // receiver: random stall, or a long hold-off when asked
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // watchdog on cycles with no item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // stimulus
   initial begin
      int          idle_plan [4][2];
      limb_type    alt;
      idle_plan = '{'{0, 0}, '{75, 0}, '{0, 75}, '{17, 17}};
      alt = limb_type'({(LIMB_BITS + 1) / 2{2'b01}});
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed operands
      send_item('0);
      send_item('{LIMB_MAX, LIMB_MAX, LIMB_MAX, LIMB_MAX, LIMB_MAX,
                  LIMB_MAX, LIMB_MAX, LIMB_MAX, LIMB_MAX, LIMB_MAX});
      send_item('{P_LOW, LIMB_MAX, LIMB_MAX, LIMB_MAX, LIMB_MAX,
                  LIMB_MAX, LIMB_MAX, LIMB_MAX, LIMB_MAX, LIMB_MAX});
      send_item('{P_LOW, LIMB_MAX, LIMB_MAX, LIMB_MAX, LIMB_MAX,
                  P_LOW, LIMB_MAX, LIMB_MAX, LIMB_MAX, LIMB_MAX});
      send_item('{limb_type'(1), '0, '0, '0, '0,
                  LIMB_MAX, LIMB_MAX, LIMB_MAX, LIMB_MAX, LIMB_MAX});
      send_item('{alt, alt, alt, alt, alt, ~alt, ~alt, ~alt, ~alt, ~alt});
      send_item('{~alt, alt, ~alt, alt, ~alt, alt, ~alt, alt, ~alt, alt});
      // each fold weight, and squares of single limbs
      for (int k = 0; k < LIMB_COUNT; k++) begin
         send_item(single_limbs(k, LIMB_COUNT - 1));
         send_item(single_limbs(k, k));
      end
      drain();

      // random phases with varying idle and stall rates
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = idle_plan[ph][0];
         stall_pct     = idle_plan[ph][1];
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (ph == 0 && n == 100) begin
               hold_request = 1'b1;
            end
            if (n == ITEMS_PER_PHASE / 2) begin
               drain();
            end
            send_item(rand_operands());
         end
         drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/mmp_pkg.sv
sv/mmp_lane.sv
sv/mmp_merge.sv
sv/modular_multiply_p25519.sv
sv/mmp_checker.sv
tb/mmp_product_checker.sv
tb/tb_top.sv
